// ===== hw/rtl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants of the 4x4 matrix-vector transform unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

   // fixed-point element and vector geometry
   localparam int DataWidth = 32;
   localparam int VecLen    = 4;
   localparam int NumLanes  = 4;
   localparam int ProdWidth = 2 * DataWidth;

   // configuration register file
   localparam int CfgWidth      = 64;
   localparam int NumRegs       = 8;
   localparam int RegIndexWidth = 4;
   localparam int RegAddrWidth  = 3;

   // register indexes
   localparam logic [RegAddrWidth-1:0] RegRow0Cols01 = 3'd0;
   localparam logic [RegAddrWidth-1:0] RegRow0Cols23 = 3'd1;
   localparam logic [RegAddrWidth-1:0] RegRow1Cols01 = 3'd2;
   localparam logic [RegAddrWidth-1:0] RegRow1Cols23 = 3'd3;
   localparam logic [RegAddrWidth-1:0] RegRow2Cols01 = 3'd4;
   localparam logic [RegAddrWidth-1:0] RegRow2Cols23 = 3'd5;
   localparam logic [RegAddrWidth-1:0] RegRow3Cols01 = 3'd6;
   localparam logic [RegAddrWidth-1:0] RegRow3Cols23 = 3'd7;

   // saturation limits
   localparam logic signed [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};

   typedef logic signed [DataWidth-1:0] fixed_type;
   typedef fixed_type [VecLen-1:0]      vec_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] in_x;
      logic signed [DataWidth-1:0] in_y;
      logic signed [DataWidth-1:0] in_z;
      logic signed [DataWidth-1:0] in_w;
   } req_payload_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] out_x;
      logic signed [DataWidth-1:0] out_y;
      logic signed [DataWidth-1:0] out_z;
      logic signed [DataWidth-1:0] out_w;
      logic                        saturated;
   } rsp_payload_type;

   // per-stage load enables shared by all lanes
   typedef struct packed {
      logic s1_en;
      logic s2_en;
      logic s3_en;
   } stage_ctrl_type;

endpackage

// ===== hw/rtl/mvt_stream_if.sv =====
// ----------------------------------------------------------------------------
// mvt_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mvt_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/matrix_vector_transform_4x4_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_unit
// Transforms one Q16.16 four-component vector per transaction by a 4x4
// matrix held in configuration registers.
// ----------------------------------------------------------------------------
// Accepts one vector per clock while the pipeline is not stalled and
// returns one result per vector. Four lanes, one per matrix row, each run
// four 32x32 multipliers in parallel followed by a pair add, a final add
// with round-half-up and a clamp; the output register follows the lane
// pipeline. Each stage loads whenever the stage after it is free, so a
// stalled result does not stop accepted vectors from moving up behind it.
// The matrix resets to identity and is written through the csr port; the
// user must write it only while the unit is idle, as the unit does not
// enforce this. Writes to an index beyond the eight registers are ignored.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mvt_pkg::RegIndexWidth-1:0]   csr_index,
   input  logic [mvt_pkg::CfgWidth-1:0]        csr_wdata,
   mvt_stream_if.sink                          req_if,
   mvt_stream_if.source                        rsp_if
);
   import mvt_pkg::*;

   localparam logic [CfgWidth-1:0] OneLo = CfgWidth'(1) << FRAC_BITS;
   localparam logic [CfgWidth-1:0] OneHi = OneLo << DataWidth;

   logic [CfgWidth-1:0] cfg_ff [NumRegs];
   logic [CfgWidth-1:0] cfg_in [NumRegs];
   logic                v1_ff, v2_ff, v3_ff;
   logic                v1_in, v2_in, v3_in;
   logic                out_ready;
   stage_ctrl_type      ctrl;
   vec_type             vec;
   vec_type             rows [NumLanes];
   vec_type             lane_value;
   logic [NumLanes-1:0] lane_sat;

   // configuration write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en && (csr_index < RegIndexWidth'(NumRegs))) begin
         cfg_in[csr_index[RegAddrWidth-1:0]] = csr_wdata;
      end
   end

   // identity matrix on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[RegRow0Cols01] <= OneLo;
         cfg_ff[RegRow0Cols23] <= '0;
         cfg_ff[RegRow1Cols01] <= OneHi;
         cfg_ff[RegRow1Cols23] <= '0;
         cfg_ff[RegRow2Cols01] <= '0;
         cfg_ff[RegRow2Cols23] <= OneLo;
         cfg_ff[RegRow3Cols01] <= '0;
         cfg_ff[RegRow3Cols23] <= OneHi;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // matrix rows: even register holds columns 0/1, odd register columns 2/3
   always_comb begin
      for (int r = 0; r < NumLanes; r++) begin
         rows[r][0] = cfg_ff[2*r][DataWidth-1:0];
         rows[r][1] = cfg_ff[2*r][CfgWidth-1:DataWidth];
         rows[r][2] = cfg_ff[2*r+1][DataWidth-1:0];
         rows[r][3] = cfg_ff[2*r+1][CfgWidth-1:DataWidth];
      end
   end

   // pipeline flow: a stage loads when it is empty or its successor loads
   always_comb begin
      ctrl.s3_en = !v3_ff || out_ready;
      ctrl.s2_en = !v2_ff || ctrl.s3_en;
      ctrl.s1_en = !v1_ff || ctrl.s2_en;
      v1_in = ctrl.s1_en ? req_if.valid : v1_ff;
      v2_in = ctrl.s2_en ? v1_ff : v2_ff;
      v3_in = ctrl.s3_en ? v2_ff : v3_ff;
   end

   assign req_if.ready = ctrl.s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign vec[0] = req_if.payload.in_x;
   assign vec[1] = req_if.payload.in_y;
   assign vec[2] = req_if.payload.in_z;
   assign vec[3] = req_if.payload.in_w;

   // one lane per matrix row
   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      mvt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .row   (rows[g]),
         .vec   (vec),
         .value (lane_value[g]),
         .sat   (lane_sat[g])
      );
   end

   mvt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (v3_ff),
      .lane_value (lane_value),
      .lane_sat   (lane_sat),
      .load_ready (out_ready),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== hw/rtl/mvt_lane.sv =====
// ----------------------------------------------------------------------------
// mvt_lane
// One matrix row dotted with the vector: multiply, pair add, final add with
// rounding and shift, then clamp to the output range.
// ----------------------------------------------------------------------------
module mvt_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  mvt_pkg::stage_ctrl_type ctrl,
   input  mvt_pkg::vec_type        row,
   input  mvt_pkg::vec_type        vec,
   output mvt_pkg::fixed_type      value,
   output logic                    sat
);
   import mvt_pkg::*;

   localparam int PairWidth = ProdWidth + 1;
   localparam int SumWidth  = ProdWidth + 2;
   // half an LSB of the result; zero when there are no fraction bits
   localparam logic signed [SumWidth-1:0] RoundConst =
      (SumWidth'(1) << FRAC_BITS) >> 1;

   logic signed [ProdWidth-1:0] prod_ff [VecLen];
   logic signed [ProdWidth-1:0] prod_in [VecLen];
   logic signed [PairWidth-1:0] pair_ff [2];
   logic signed [PairWidth-1:0] pair_in [2];
   logic signed [SumWidth-1:0]  rnd_ff;
   logic signed [SumWidth-1:0]  rnd_in;
   logic signed [SumWidth-1:0]  total;
   logic [SumWidth-DataWidth:0] top_bits;

   // stage 1: element products, sign-extended 32x32
   always_comb begin
      for (int j = 0; j < VecLen; j++) begin
         prod_in[j] = ProdWidth'(row[j]) * ProdWidth'(vec[j]);
      end
   end

   // stage 2: pairwise sums
   always_comb begin
      pair_in[0] = PairWidth'(prod_ff[0]) + PairWidth'(prod_ff[1]);
      pair_in[1] = PairWidth'(prod_ff[2]) + PairWidth'(prod_ff[3]);
   end

   // stage 3: full sum, round half up, drop fraction bits
   always_comb begin
      total  = SumWidth'(pair_ff[0]) + SumWidth'(pair_ff[1]) + RoundConst;
      rnd_in = total >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.s2_en) begin
         pair_ff <= pair_in;
      end
      if (ctrl.s3_en) begin
         rnd_ff <= rnd_in;
      end
   end

   // clamp: in range when all bits from the result sign up agree
   always_comb begin
      top_bits = rnd_ff[SumWidth-1:DataWidth-1];
      if ((&top_bits) || !(|top_bits)) begin
         value = rnd_ff[DataWidth-1:0];
         sat   = 1'b0;
      end else begin
         value = rnd_ff[SumWidth-1] ? MinVal : MaxVal;
         sat   = 1'b1;
      end
   end

endmodule

// ===== hw/rtl/mvt_merge.sv =====
// ----------------------------------------------------------------------------
// mvt_merge
// Gathers the lane results into one response, folds the clamp flags and
// holds the response in the output register until it is taken.
// ----------------------------------------------------------------------------
module mvt_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  lane_valid,
   input  mvt_pkg::vec_type      lane_value,
   input  logic [mvt_pkg::NumLanes-1:0] lane_sat,
   output logic                  load_ready,
   mvt_stream_if.source          rsp_if
);
   import mvt_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type data_ff;
   rsp_payload_type data_in;

   // output slot is free when empty or being drained
   assign load_ready = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = load_ready ? lane_valid : valid_ff;
      data_in.out_x     = lane_value[0];
      data_in.out_y     = lane_value[1];
      data_in.out_z     = lane_value[2];
      data_in.out_w     = lane_value[3];
      data_in.saturated = |lane_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && lane_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_if.valid   = valid_ff;
   assign rsp_if.payload = data_ff;

endmodule
